// ===== rtl/core/isort_pkg.sv =====
// isort_pkg: shared types and constants of the insertion sorter.
// Command and status words between controller and datapath, controller states.
// No dependencies.
`default_nettype none

package isort_pkg;

	localparam int WORD_W = 32;

	typedef struct packed {
		logic insert;
		logic drop;
		logic emit;
	} isort_cmd_t;

	typedef struct packed {
		logic full;
		logic one_left;
	} isort_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} isort_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/isort_ctrl.sv =====
// isort_ctrl: controller state machine of the insertion sorter.
// Decodes the start handshake into insert and drop commands; issues emit after a last word.
// Depends on isort_pkg.
`default_nettype none

module isort_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 last,
	input  wire isort_pkg::isort_sts_t sts,
	output isort_pkg::isort_cmd_t     cmd,
	output logic                      busy
);
	import isort_pkg::*;

	isort_state_t state_q;
	isort_state_t state_d;
	logic         accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d    = state_q;
		cmd.insert = 1'b0;
		cmd.drop   = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.insert = accept && !sts.full;
				cmd.drop   = accept && sts.full;
				if (accept && last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/isort_datapath.sv =====
// isort_datapath: row of compare-and-shift cells, fill count, overflow flag
// and result registers of the insertion sorter. Depends on isort_pkg.
`default_nettype none

module isort_datapath #(
	parameter int DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire isort_pkg::isort_cmd_t               cmd,
	input  wire logic signed [isort_pkg::WORD_W-1:0] value,
	output isort_pkg::isort_sts_t                    sts,
	output logic                                     valid,
	output logic signed [isort_pkg::WORD_W-1:0]      sorted_value,
	output logic                                     end_of_set,
	output logic                                     overflow
);
	import isort_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [WORD_W-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]         gt;
	logic [CNT_W-1:0]         count_q;
	logic                     flag_q;
	logic                     valid_q;
	logic signed [WORD_W-1:0] sorted_value_q;
	logic                     end_of_set_q;
	logic                     overflow_q;

	assign sts.full     = (count_q == CNT_W'(DEPTH));
	assign sts.one_left = (count_q == CNT_W'(1));

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (cell_q[i] > value);
		end
	end

	// Insert: shift larger entries up one cell; emit: shift all down one cell.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				cell_q[i] <= cell_q[i + 1];
			end
		end else if (cmd.insert) begin
			if (gt[0] || count_q == '0) begin
				cell_q[0] <= value;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (gt[i] || CNT_W'(i) == count_q) begin
					cell_q[i] <= gt[i - 1] ? cell_q[i - 1] : value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.emit) begin
				count_q <= count_q - CNT_W'(1);
				if (sts.one_left) begin
					flag_q <= 1'b0;
				end
			end else if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.drop) begin
				flag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sorted_value_q <= cell_q[0];
			end_of_set_q   <= sts.one_left;
			overflow_q     <= flag_q;
		end
	end

	assign valid        = valid_q;
	assign sorted_value = sorted_value_q;
	assign end_of_set   = end_of_set_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

// ===== rtl/core/insertion_sorter.sv =====
// insertion_sorter: stable ascending sort of one set of signed words.
// Top level; instantiates isort_ctrl and isort_datapath, uses isort_pkg.
//
//  channel  | handshake          | words
//  ---------+--------------------+-------------------------------------
//  input    | start & !busy      | value, last
//  result   | valid (one cycle)  | sorted_value, end_of_set, overflow
//
// Each input word is inserted by the row of DEPTH compare-and-shift cells
// (dropped when full), so words may be accepted every cycle while loading.
// A word marked last starts output: a set of N stored words gives N results
// on consecutive cycles, one cell shift per cycle; busy is high meanwhile.
// The next word may be accepted in the cycle that shows the final result.
// Reset clears fill count, overflow flag and state; cell contents need none.
// The receiver cannot stall: each result holds for exactly one cycle.
`default_nettype none

module insertion_sorter #(
	parameter int DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [isort_pkg::WORD_W-1:0] value,
	input  wire logic                                last,
	output logic                                     valid,
	output logic signed [isort_pkg::WORD_W-1:0]      sorted_value,
	output logic                                     end_of_set,
	output logic                                     overflow
);
	import isort_pkg::*;

	isort_cmd_t cmd;
	isort_sts_t sts;

	isort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	isort_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.sts          (sts),
		.valid        (valid),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set),
		.overflow     (overflow)
	);

endmodule

`default_nettype wire
